// ===== hdl/spectrum_band_threshold_bar_core_macros.svh =====
// Assertion macros used by the spectrum band threshold bar port checker.
`ifndef SPECTRUM_BAND_THRESHOLD_BAR_CORE_MACROS_SVH
`define SPECTRUM_BAND_THRESHOLD_BAR_CORE_MACROS_SVH

// Condition must hold in the cycle after the trigger, outside reset.
`define SBTB_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("sbtb port check failed");

// Condition must hold in the same cycle as the trigger, outside reset.
`define SBTB_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("sbtb port check failed");

// Checked through reset as well.
`define SBTB_ASSERT_RESET(label, trig, cond) \
   label: assert property (@(posedge clock) (trig) |=> (cond)) \
      else $error("sbtb reset check failed");

`endif

// ===== hdl/sbtb_pkg.sv =====
// Shared constants and types for the spectrum band threshold bar.
package sbtb_pkg;

   localparam int MAG_W      = 16;
   localparam int THR_W      = 16;
   localparam int CNT_W      = 11;
   localparam int LED_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT       = 1'b1;

   localparam logic [THR_W-1:0] THR_RESET = 16'd20;
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd64;

   localparam int              SETTLE_W      = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [LED_W-1:0] led_type;

endpackage

// ===== hdl/spectrum_band_threshold_bar_core.sv =====
// Spectrum band threshold bar: takes one magnitude bin per cycle while req_stall is low,
// sums the bins of each of GROUPS equal bands (DC left out of band 0), and after the last
// bin of a frame returns one LED pattern with bit g set when band g's mean is above
// level_threshold. One bin is taken every clock cycle unless req_stall holds it off; the
// pattern reaches rsp_ through three registered steps (bin update, threshold product,
// compare). A pattern held on rsp_ stalls the input only once the next pattern has reached
// the end of the pipe behind it. After reset and after every csr_ write the input is held
// off while the band boundaries are rebuilt from bin_count (one reciprocal multiply, then
// one boundary multiply per band). A frame with bin_count of zero yields no pattern.
module spectrum_band_threshold_bar_core #(
   parameter int GROUPS   = 8,
   parameter int MAX_BINS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sbtb_pkg::mag_type                     req_magnitude,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sbtb_pkg::led_type                     rsp_led_pattern,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbtb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbtb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int NW   = $clog2(MAX_BINS + 1);
   localparam int GW   = $clog2(GROUPS);
   localparam int RSH  = NW + GW;
   localparam int RW   = RSH + 1;
   localparam int QW   = NW + RW;
   localparam int CW   = (NW > sbtb_pkg::CNT_W) ? NW : sbtb_pkg::CNT_W;
   localparam int BW   = NW + 6;
   localparam int SW   = sbtb_pkg::MAG_W + NW;
   localparam int TW   = sbtb_pkg::THR_W + 1;
   localparam int PW   = TW + NW;
   localparam int OHW  = (GROUPS > sbtb_pkg::LED_W) ? GROUPS : sbtb_pkg::LED_W;
   localparam int RECIP_I = ((2 ** RSH) + GROUPS - 1) / GROUPS;
   localparam logic [RW-1:0] RECIP      = RW'(RECIP_I);
   localparam logic [CW-1:0] MAX_BINS_C = CW'(MAX_BINS);
   localparam logic [NW-1:0] MAX_BINS_N = NW'(MAX_BINS);

   // configuration
   logic [sbtb_pkg::THR_W-1:0]    thr_ff, thr_in;
   logic [sbtb_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [sbtb_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic                          csr_write;

   logic [CW-1:0] cnt_ext;
   logic [NW-1:0] neff_in, neff_ff;
   logic [QW-1:0] quot_prod;
   logic [NW-1:0] per_q, per_in, per_ff;
   logic [BW-1:0] bound_in [GROUPS];
   logic [BW-1:0] bound_ff [GROUPS];

   // handshake
   logic enable, accept;

   // frame state
   logic [NW-1:0] idx_ff, idx_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] mem_ff, mem_in;

   // bin update
   logic [NW-1:0]  base_idx, b;
   logic [SW-1:0]  base_sum, s0, sum1;
   logic [NW-1:0]  base_mem, m0, mem1;
   logic [NW:0]    b_plus;
   logic           nz, wrap, in_range, add, end_grp, last_bin;
   logic [OHW-1:0] ge;
   logic [GROUPS-1:0] at_end;
   sbtb_pkg::led_type hot;

   // stage 1
   logic              v1_ff, done1_ff, emit1_ff, clr1_ff;
   logic [SW-1:0]     sum1_ff;
   logic [NW-1:0]     mem1_ff;
   sbtb_pkg::led_type hot1_ff;

   // stage 2
   logic              v2_ff, done2_ff, emit2_ff, clr2_ff;
   logic [SW-1:0]     sum2_ff;
   logic [PW-1:0]     need2_ff;
   sbtb_pkg::led_type hot2_ff;

   // pattern and output
   sbtb_pkg::led_type pat_ff, pat_in, pat_new, pat_base;
   sbtb_pkg::led_type out_ff;
   logic              out_valid_ff, out_valid_in, lit;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      thr_in = thr_ff;
      cnt_in = cnt_ff;
      if (csr_write) begin
         case (csr_index)
            sbtb_pkg::CSR_LEVEL_THRESHOLD: thr_in = csr_wdata[sbtb_pkg::THR_W-1:0];
            sbtb_pkg::CSR_BIN_COUNT:       cnt_in = csr_wdata[sbtb_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
      if (csr_write) begin
         settle_in = sbtb_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= sbtb_pkg::THR_RESET;
         cnt_ff    <= sbtb_pkg::CNT_RESET;
         settle_ff <= sbtb_pkg::SETTLE_CYCLES;
      end else begin
         thr_ff    <= thr_in;
         cnt_ff    <= cnt_in;
         settle_ff <= settle_in;
      end
   end

   // effective bin count and bins per band; floor(n/GROUPS) by exact reciprocal
   always_comb begin
      cnt_ext   = CW'(cnt_ff);
      neff_in   = (cnt_ext > MAX_BINS_C) ? MAX_BINS_N : cnt_ext[NW-1:0];
      quot_prod = QW'(neff_in) * QW'(RECIP);
      per_q     = quot_prod[RSH +: NW];
      per_in    = (per_q == '0) ? NW'(1) : per_q;
      for (int k = 0; k < GROUPS; k++) begin
         bound_in[k] = BW'(per_ff) * BW'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      neff_ff <= neff_in;
      per_ff  <= per_in;
      for (int k = 0; k < GROUPS; k++) begin
         bound_ff[k] <= bound_in[k];
      end
   end

   // ---------------------------------------------------------------- handshake
   // the pipe only stops when a finished pattern cannot move into a held output
   assign enable    = !(out_valid_ff && rsp_stall && v2_ff && emit2_ff);
   assign req_stall = (settle_ff != '0) || !enable;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- bin update
   always_comb begin
      nz       = neff_ff != '0;
      base_idx = req_frame_start ? '0 : idx_ff;
      base_sum = req_frame_start ? '0 : sum_ff;
      base_mem = req_frame_start ? '0 : mem_ff;
      // count lowered below the current position: restart the frame
      wrap     = nz && (base_idx >= neff_ff);
      b        = wrap ? '0 : base_idx;
      s0       = wrap ? '0 : base_sum;
      m0       = wrap ? '0 : base_mem;
      b_plus   = {1'b0, b} + 1'b1;
      last_bin = b_plus == {1'b0, neff_ff};

      for (int k = 0; k < GROUPS; k++) begin
         ge[k]     = BW'(b) >= bound_ff[k];
         at_end[k] = BW'(b_plus) == bound_ff[k];
      end
      for (int k = GROUPS; k < OHW; k++) begin
         ge[k] = 1'b1;
      end
      in_range = !ge[GROUPS-1];

      // one-hot of the band holding this bin, LED bands only
      hot[0] = !ge[0];
      for (int k = 1; k < sbtb_pkg::LED_W; k++) begin
         hot[k] = !ge[k] && ge[k-1];
      end

      add     = in_range && (b != '0);
      sum1    = s0 + (add ? SW'(req_magnitude) : '0);
      mem1    = m0 + NW'(add);
      end_grp = in_range && ((|at_end) || last_bin);

      idx_in = idx_ff;
      sum_in = sum_ff;
      mem_in = mem_ff;
      if (accept) begin
         if (!nz) begin
            idx_in = base_idx;
            sum_in = base_sum;
            mem_in = base_mem;
         end else if (last_bin) begin
            idx_in = '0;
            sum_in = '0;
            mem_in = '0;
         end else begin
            idx_in = b_plus[NW-1:0];
            sum_in = end_grp ? '0 : sum1;
            mem_in = end_grp ? '0 : mem1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sum_ff <= '0;
         mem_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         mem_ff <= mem_in;
      end
   end

   // ---------------------------------------------------------------- pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         done1_ff <= 1'b0;
         emit1_ff <= 1'b0;
         clr1_ff  <= 1'b0;
         v2_ff    <= 1'b0;
         done2_ff <= 1'b0;
         emit2_ff <= 1'b0;
         clr2_ff  <= 1'b0;
      end else if (enable) begin
         v1_ff    <= accept;
         done1_ff <= nz && end_grp && (mem1 != '0);
         emit1_ff <= nz && last_bin;
         clr1_ff  <= req_frame_start || wrap;
         v2_ff    <= v1_ff;
         done2_ff <= done1_ff;
         emit2_ff <= emit1_ff;
         clr2_ff  <= clr1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum1_ff  <= sum1;
         mem1_ff  <= mem1;
         hot1_ff  <= hot;
         sum2_ff  <= sum1_ff;
         need2_ff <= PW'(TW'(thr_ff) + 1'b1) * PW'(mem1_ff);
         hot2_ff  <= hot1_ff;
      end
   end

   // ---------------------------------------------------------------- pattern and output
   always_comb begin
      pat_base = clr2_ff ? '0 : pat_ff;
      lit      = done2_ff && (PW'(sum2_ff) >= need2_ff);
      pat_new  = pat_base | (lit ? hot2_ff : '0);
      pat_in   = pat_ff;
      if (enable && v2_ff) begin
         pat_in = emit2_ff ? '0 : pat_new;
      end
      if (enable && v2_ff && emit2_ff) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && v2_ff && emit2_ff) begin
         out_ff <= pat_new;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_led_pattern = out_ff;

endmodule

// ===== hdl/sbtb_port_checker.sv =====
// Port-level checker for the spectrum band threshold bar, bound to the core module.
`include "spectrum_band_threshold_bar_core_macros.svh"

module sbtb_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sbtb_pkg::led_type rsp_led_pattern,
   input logic              csr_valid,
   input logic              csr_ready
);

   // stalled result transaction keeps its pattern
   `SBTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_led_pattern))

   // a result transaction always carries a known pattern
   `SBTB_ASSERT_NOW(a_rsp_known, rsp_valid, !$isunknown(rsp_led_pattern))

   // band boundaries are rebuilt after a register write
   `SBTB_ASSERT_NEXT(a_csr_settle, csr_valid && csr_ready, req_stall && !(req_valid && !req_stall))

   `SBTB_ASSERT_RESET(a_reset_clean, reset, !rsp_valid && req_stall)

endmodule

bind spectrum_band_threshold_bar_core sbtb_port_checker u_sbtb_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_led_pattern (rsp_led_pattern),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);
